// ===== design/ecdf_pkg.sv =====
// Shared types and constants for the empirical CDF builder.
// Used by the RAM-free front, the sort/emit engine and the top level.
`default_nettype none
package ecdf_pkg;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int FULL_SCALE = 10000;
    localparam int PCT_W = 14;
    localparam int VAL_W = 64;

    // Item passed from the front to the back through the queue.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } sample_t;

    // Result item handed to the output register.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [PCT_W-1:0] pct;
        logic             ovf;
        logic             last;
    } point_t;
endpackage
`default_nettype wire

// ===== design/ecdf_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ecdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Read first port access, registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== design/ecdf_queue.sv =====
// Short two-entry queue between the front and back parts.
// Depends on ecdf_pkg.
`default_nettype none
module ecdf_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ecdf_pkg::sample_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ecdf_pkg::sample_t     out_data
);
    ecdf_pkg::sample_t buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== design/ecdf_back.sv =====
// Back part: stores samples, insertion-sorts them in RAM, emits CDF points.
// Depends on ecdf_pkg and ecdf_ram.
`default_nettype none
module ecdf_back #(
    parameter int MAX_SAMPLES = ecdf_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ecdf_pkg::sample_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ecdf_pkg::point_t       out_data
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int NW = CW + ecdf_pkg::PCT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KEYRD  = 4'd1;
    localparam logic [3:0] S_KEYWT  = 4'd2;
    localparam logic [3:0] S_CMPRD  = 4'd3;
    localparam logic [3:0] S_CMPWT  = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_EMRD   = 4'd6;
    localparam logic [3:0] S_EMWT   = 4'd7;
    localparam logic [3:0] S_EMCHK  = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_PUT    = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [63:0] key_reg, key_next, curr_reg, curr_next;
    logic        fin_reg, fin_next;
    logic [CW-1:0] pcnt_reg, pcnt_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [ecdf_pkg::PCT_W-1:0] q_reg, q_next;
    logic [4:0]  bit_reg, bit_next;
    logic [63:0] pval_reg, pval_next;
    logic        plast_reg, plast_next;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [63:0] ram_wdata, ram_rdata;

    ecdf_pkg::point_t obuf_reg;
    logic        ovalid_reg;
    logic        load_out;

    logic [NW-1:0] dsh;

    ecdf_ram #(.WIDTH(64), .DEPTH(MAX_SAMPLES)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = obuf_reg;
    assign dsh = {{ecdf_pkg::PCT_W{1'b0}}, count_reg} << bit_reg;

    // Sequencer: store, sort with one RAM access a cycle, then scan and divide.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        key_next   = key_reg;
        curr_next  = curr_reg;
        fin_next   = fin_reg;
        pcnt_next  = pcnt_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        pval_next  = pval_reg;
        plast_next = plast_reg;
        ram_we     = 1'b0;
        ram_addr   = i_reg[AW-1:0];
        ram_wdata  = key_reg;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ram_addr  = count_reg[AW-1:0];
                ram_wdata = in_data.value;
                if (in_valid)
                begin
                    if (count_reg < CW'(MAX_SAMPLES))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_data.last)
                    begin
                        i_next     = CW'(1);
                        state_next = S_KEYRD;
                    end
                end
            end
            S_KEYRD:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next     = '0;
                    ram_addr   = '0;
                    state_next = S_EMWT;
                    fin_next   = 1'b0;
                end
                else
                begin
                    state_next = S_KEYWT;
                end
            end
            S_KEYWT:
            begin
                key_next   = ram_rdata;
                j_next     = i_reg;
                state_next = S_CMPRD;
            end
            S_CMPRD:
            begin
                if (j_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_addr   = '0;
                    i_next     = i_reg + 1'b1;
                    state_next = S_KEYRD;
                end
                else
                begin
                    ram_addr   = AW'(j_reg - 1'b1);
                    state_next = S_CMPWT;
                end
            end
            S_CMPWT:
            begin
                ram_addr   = AW'(j_reg - 1'b1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                ram_addr = j_reg[AW-1:0];
                if (ram_rdata > key_reg)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    j_next     = j_reg - 1'b1;
                    state_next = S_CMPRD;
                end
                else
                begin
                    ram_we     = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_KEYRD;
                end
            end
            S_EMWT:
            begin
                // First sorted value arrives.
                ram_addr   = '0;
                state_next = S_EMRD;
            end
            S_EMRD:
            begin
                curr_next  = ram_rdata;
                i_next     = CW'(1);
                state_next = S_EMCHK;
                ram_addr   = AW'(1);
            end
            S_EMCHK:
            begin
                // Issue read of entry i, compare once it lands.
                ram_addr = i_reg[AW-1:0];
                if (i_reg >= count_reg)
                begin
                    pval_next  = curr_reg;
                    pcnt_next  = count_reg;
                    plast_next = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Read data for entry i is valid here.
                ram_addr = i_reg[AW-1:0];
                if (ram_rdata != curr_reg)
                begin
                    pval_next  = curr_reg;
                    pcnt_next  = i_reg;
                    plast_next = 1'b0;
                    curr_next  = ram_rdata;
                    state_next = S_DIV;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    ram_addr   = AW'(i_reg + 1'b1);
                    state_next = S_EMCHK;
                end
                if (ram_rdata != curr_reg)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                // Set up restoring division of 10000*cnt by n.
                rem_next   = NW'(pcnt_reg) * NW'(ecdf_pkg::FULL_SCALE);
                q_next     = '0;
                bit_next   = 5'(ecdf_pkg::PCT_W - 1);
                state_next = S_PUT;
                fin_next   = 1'b0;
            end
            S_PUT:
            begin
                if (!fin_reg)
                begin
                    if (rem_reg >= dsh)
                    begin
                        rem_next = rem_reg - dsh;
                        q_next   = q_reg | (ecdf_pkg::PCT_W'(1) << bit_reg);
                    end
                    if (bit_reg == 5'd0)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                    end
                end
                else if (!ovalid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    fin_next = 1'b0;
                    if (plast_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_addr   = i_reg[AW-1:0];
                        state_next = S_EMCHK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            fin_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            fin_reg   <= fin_next;
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        key_reg   <= key_next;
        curr_reg  <= curr_next;
        pcnt_reg  <= pcnt_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
        pval_reg  <= pval_next;
        plast_reg <= plast_next;
        if (load_out)
        begin
            obuf_reg.value <= pval_reg;
            obuf_reg.pct   <= q_reg;
            obuf_reg.ovf   <= ovf_reg;
            obuf_reg.last  <= plast_reg;
        end
    end
endmodule
`default_nettype wire

// ===== design/empirical_cdf_builder.sv =====
// Empirical CDF builder. While collecting, one sample item is taken each cycle. The last
// sample starts an insertion sort over the sample RAM with one port, O(n^2): each key is read,
// then larger elements are moved up one at a time. Then comes one point per distinct value,
// each with a restoring divide; repeated samples add scan steps before the next point.
// Result output is registered, and a stalled receiver holds the back part.
// Reset clears the sample count, overflow flag and control; RAM is not cleared.
`default_nettype none
module empirical_cdf_builder #(
    parameter int MAX_SAMPLES = ecdf_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // sample_value
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // point_value, cumulative in 0.01 percent units, pad
    output logic             m_tuser,   // overflowed
    output logic             m_tlast    // last_point
);
    ecdf_pkg::sample_t s_item, q_item;
    ecdf_pkg::point_t  pt;
    logic q_valid, q_ready;

    assign s_item.value = s_tdata;
    assign s_item.last  = s_tlast;

    ecdf_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_item)
    );

    ecdf_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(pt)
    );

    assign m_tdata = {2'b00, pt.pct, pt.value};
    assign m_tuser = pt.ovf;
    assign m_tlast = pt.last;
endmodule
`default_nettype wire

// ===== dv/empirical_cdf_builder_test.sv =====
// Testbench for the empirical CDF builder: sends sample sets, predicts the CDF points
// of each set in a local sorter and checks every result item field by field.
// Depends on ecdf_pkg and the empirical_cdf_builder RTL.
`timescale 1ns / 100ps
`default_nettype none
module empirical_cdf_builder_test;

    localparam int DEPTH = ecdf_pkg::MAX_SAMPLES_DEF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    empirical_cdf_builder DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // Predictor state: the samples of the open set and the dropped-sample flag.
    logic [63:0]      set_samples[$];
    logic             set_dropped;
    ecdf_pkg::point_t expected_points[$];

    int  mismatches;
    bit  failed;
    bit  idle_enable;
    bit  hold_results;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Adds one sample to the predicted set and, on the final one, builds its CDF.
    task automatic predict_sample(input logic [63:0] value, input logic final_one);
        logic [63:0]      sorted[$];
        int               n;
        ecdf_pkg::point_t p;
        begin
            if (set_samples.size() < DEPTH)
                set_samples.push_back(value);
            else
                set_dropped = 1'b1;
            if (final_one)
            begin
                sorted = set_samples;
                sorted.sort();
                n = sorted.size();
                for (int i = 0; i < n; i++)
                begin
                    if (i == n - 1 || sorted[i + 1] != sorted[i])
                    begin
                        p.value = sorted[i];
                        p.pct   = ecdf_pkg::PCT_W'((64'(ecdf_pkg::FULL_SCALE) * 64'(i + 1))
                                  / 64'(n));
                        p.ovf   = set_dropped;
                        p.last  = (i == n - 1);
                        expected_points.push_back(p);
                    end
                end
                set_samples.delete();
                set_dropped = 1'b0;
            end
        end
    endtask

    // Offers one item, with random idle cycles, and waits for its acceptance.
    // The valid stays high afterwards until the next call or a drain replaces it.
    task automatic send_sample(input logic [63:0] value, input logic final_one);
        begin
            if (idle_enable && $urandom_range(99) < 35)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (idle_enable && $urandom_range(99) < 35)
                    @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= value;
            s_tlast  <= final_one;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            predict_sample(value, final_one);
        end
    endtask

    function automatic logic [63:0] rand_value(input int mode);
        logic [63:0] v;
        begin
            v = {$urandom(), $urandom()};
            case (mode)
                0: v = 64'($urandom_range(7));
                1: v = 64'hFFFF_FFFF_FFFF_FFF8 | 64'($urandom_range(7));
                default: ;
            endcase
            return v;
        end
    endfunction

    task automatic send_set(input int count);
        int mode;
        begin
            mode = $urandom_range(2);
            for (int i = 0; i < count; i++)
                send_sample(rand_value(mode), i == count - 1);
        end
    endtask

    // Stops offering items and waits until every expected result has come.
    task automatic wait_results_done();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (expected_points.size() != 0)
                @(posedge clk);
        end
    endtask

    // Extremes, a single sample, duplicates and ordering.
    task automatic test_directed();
        begin
            send_sample(64'd0, 1'b1);
            send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
            send_sample(64'd0, 1'b0);
            send_sample(64'd5, 1'b0);
            send_sample(64'd5, 1'b0);
            send_sample(64'hAAAA_5555_AAAA_5555, 1'b0);
            send_sample(64'h5555_AAAA_5555_AAAA, 1'b1);
            send_sample(64'd9, 1'b0);
            send_sample(64'd9, 1'b0);
            send_sample(64'd9, 1'b1);
            send_sample(64'd3, 1'b0);
            send_sample(64'd1, 1'b0);
            send_sample(64'd2, 1'b1);
            wait_results_done();
        end
    endtask

    // A full store and then overflow, with the final sample dropped too.
    task automatic test_overflow();
        begin
            for (int i = 0; i < DEPTH; i++)
                send_sample(64'(DEPTH - i) * 64'h0100_0000_0000_0001, 1'b0);
            send_sample(64'd1234, 1'b0);
            send_sample(64'd99, 1'b1);
            wait_results_done();
            // Exactly full, no drop.
            send_set(DEPTH);
            wait_results_done();
        end
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        begin
            hold_results = 1'b1;
            send_set(6);
            send_set(5);
            send_set(4);
            wait_results_done();
        end
    endtask

    // Random sets, mostly small, with and without idling.
    task automatic test_random();
        begin
            idle_enable = 1'b0;
            for (int k = 0; k < 4; k++)
                send_set($urandom_range(1, 4));
            idle_enable = 1'b1;
            for (int k = 0; k < 6; k++)
                send_set($urandom_range(1, 8));
            wait_results_done();
            // Pause until drained, then a last burst.
            for (int k = 0; k < 3; k++)
                send_set($urandom_range(1, 12));
            wait_results_done();
        end
    endtask

    // Receiver: random stalls, plus a long counted hold when requested.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                m_tready <= 1'b0;
                for (int c = 0; c < 600; c++)
                    @(posedge clk);
                hold_results = 1'b0;
            end
            m_tready <= !(idle_enable && $urandom_range(99) < 35);
        end
    end

    // Checks each accepted result item against the oldest expectation.
    always @(posedge clk)
    begin
        ecdf_pkg::point_t exp_p;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_points.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point value=%h", m_tdata[63:0]);
            end
            else
            begin
                exp_p = expected_points.pop_front();
                if (m_tdata[63:0] !== exp_p.value || m_tdata[77:64] !== exp_p.pct ||
                    m_tdata[79:78] !== 2'b00 ||
                    m_tuser !== exp_p.ovf || m_tlast !== exp_p.last)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 exp_p.value, exp_p.pct, exp_p.ovf, exp_p.last,
                                 m_tdata[63:0], m_tdata[77:64], m_tuser, m_tlast);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        set_dropped = 1'b0;
        mismatches = 0;
        failed = 1'b0;
        idle_enable = 1'b1;
        hold_results = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        repeat (200) @(posedge clk);
        if (!failed && expected_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
design/ecdf_pkg.sv
design/ecdf_ram.sv
design/ecdf_queue.sv
design/ecdf_back.sv
design/empirical_cdf_builder.sv
dv/empirical_cdf_builder_test.sv
